// ===== sv/lts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

   // Character codes the scanner treats specially
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;

   // Saturation limits of the two number kinds
   localparam logic [63:0] NAT_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

   localparam logic [7:0] MAX_TOKENS_RESET = 8'd10;

   // Result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      KIND_NEG   = 3'd0,
      KIND_NAT   = 3'd1,
      KIND_IDENT = 3'd2,
      KIND_OTHER = 3'd3,
      KIND_END   = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] magnitude;
      logic [15:0] start_offset;
      logic [15:0] token_length;
      logic        last_of_group;
   } token_type;

   // Up to two tokens come out of one scanned byte
   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT)
         || (c == CH_FF) || (c == CH_CR);
   endfunction

endpackage

`default_nettype wire

// ===== sv/lts_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text byte channel
interface lts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

// Token channel
interface lts_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [63:0] magnitude;
   logic [15:0] start_offset;
   logic [15:0] token_length;
   logic        last_of_group;

   modport source (output valid, output token_kind, output magnitude, output start_offset,
                   output token_length, output last_of_group, input ready);
   modport sink (input valid, input token_kind, input magnitude, input start_offset,
                 input token_length, input last_of_group, output ready);
endinterface

`default_nettype wire

// ===== sv/line_token_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Line token scanner: takes one text byte per cycle while the result queue has room and
// returns tokens (kind, magnitude, start offset, length, group-last flag). A byte passes
// an input register and waits there until the four-entry result queue has room for two
// tokens; it is then scanned, and the tokens it releases are written into the queue at
// the end of that scan and offered on the result channel from the queue head. Since the
// result channel moves one token per cycle while ready is high, a byte that yields two
// tokens (a lone minus followed by a one-character other token or end of text) costs
// extra output bandwidth. max_tokens is written through csr_wr_en/csr_wr_data and
// resets to 10; write it only while no text is in flight.
module line_token_scanner
   import lts_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   lts_req_if.sink         req_chan,
   lts_rsp_if.source       rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic [7:0] max_tokens_ff;
   logic       advance;
   logic       room;
   logic       req_take;
   push_type   push;
   token_type  out_token;
   logic       out_valid;

   // Move the held byte into the scanner when the queue can absorb two tokens
   assign advance          = in_valid_ff && room;
   assign req_chan.ready   = !in_valid_ff || advance;
   assign req_take         = req_chan.valid && req_chan.ready;
   assign in_valid_in      = req_take || (in_valid_ff && !advance);
   assign in_byte_in       = req_take ? req_chan.text_byte : in_byte_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   // Group size register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_tokens_ff <= MAX_TOKENS_RESET;
      end else if (csr_wr_en) begin
         max_tokens_ff <= csr_wr_data;
      end
   end

   lts_scanner #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scanner (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .text_byte  (in_byte_ff),
      .max_tokens (max_tokens_ff),
      .push       (push)
   );

   lts_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_chan.valid && rsp_chan.ready),
      .room      (room),
      .out_valid (out_valid),
      .out_token (out_token)
   );

   // Drive the result channel from the queue head
   assign rsp_chan.valid         = out_valid;
   assign rsp_chan.token_kind    = out_token.kind;
   assign rsp_chan.magnitude     = out_token.magnitude;
   assign rsp_chan.start_offset  = out_token.start_offset;
   assign rsp_chan.token_length  = out_token.token_length;
   assign rsp_chan.last_of_group = out_token.last_of_group;

   // Two tokens from one byte only follow a lone minus
   a_pair_after_minus: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.first.kind == KIND_OTHER)
      else $error("two tokens without a leading minus token");

   // An end marker always closes its group
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.token_kind == KIND_END |-> rsp_chan.last_of_group)
      else $error("end marker not marked last");

   // A held byte waits unchanged until the scanner takes it
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held byte lost or changed");

   // Scanner never pushes while the queue lacks room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("token pushed into a full queue");

endmodule

`default_nettype wire

// ===== sv/lts_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lts_scanner
   import lts_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] text_byte,
   input  logic [7:0] max_tokens,
   output push_type   push
);

   localparam int ExtW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

   typedef enum logic [3:0] {
      PH_BETWEEN = 4'b0001,
      PH_MINUS   = 4'b0010,
      PH_NUMBER  = 4'b0100,
      PH_IDENT   = 4'b1000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [63:0]            acc_ff, acc_in;
   logic                   sat_ff, sat_in;
   logic                   neg_ff, neg_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [7:0]             gc_ff, gc_in;

   logic                   digit;
   logic                   ends;
   logic                   fresh;
   logic                   neg_src;
   logic [63:0]            acc_src;
   logic                   sat_src;
   logic [63:0]            limit;
   logic [67:0]            prod;
   logic [63:0]            acc_new;
   logic                   sat_new;
   logic [7:0]             eff_max;
   logic [OFFSET_BITS-1:0] len;
   logic                   scan_free;
   logic                   last;
   token_type              tok;

   // Offsets are reported in 16 bits whatever the counter width
   function automatic logic [15:0] to16(logic [OFFSET_BITS-1:0] v);
      logic [ExtW-1:0] w;
      w = ExtW'(v);
      return w[15:0];
   endfunction

   function automatic logic group_full(logic [7:0] gc, logic [7:0] lim);
      return ({1'b0, gc} + 9'd1) >= {1'b0, lim};
   endfunction

   function automatic token_type form_token(kind_type kind, logic [63:0] mag,
                                            logic [15:0] start, logic [15:0] length,
                                            logic closes);
      token_type t;
      t.kind          = kind;
      t.magnitude     = mag;
      t.start_offset  = start;
      t.token_length  = length;
      t.last_of_group = closes;
      return t;
   endfunction

   assign digit   = is_digit(text_byte);
   assign ends    = (text_byte == CH_LF) || (text_byte == CH_NUL);
   assign eff_max = (max_tokens == 8'd0) ? 8'd1 : max_tokens;
   assign len     = pos_ff - start_ff;
   assign fresh   = digit && ((phase_ff == PH_BETWEEN) || (phase_ff == PH_MINUS));

   // Decimal accumulate: acc*10 + digit, saturating at the kind's limit
   always_comb begin
      neg_src = fresh ? (phase_ff == PH_MINUS) : neg_ff;
      acc_src = fresh ? 64'd0 : acc_ff;
      sat_src = fresh ? 1'b0 : sat_ff;
      limit   = neg_src ? NEG_LIMIT : NAT_LIMIT;
      prod    = ({4'b0, acc_src} << 3) + ({4'b0, acc_src} << 1) + {64'b0, text_byte[3:0]};
      if (sat_src || (prod > {4'b0, limit})) begin
         acc_new = limit;
         sat_new = 1'b1;
      end else begin
         acc_new = prod[63:0];
         sat_new = 1'b0;
      end
   end

   // Scan one byte: extend or close the running token, or start a new one
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      sat_in    = sat_ff;
      neg_in    = neg_ff;
      start_in  = start_ff;
      pos_in    = pos_ff;
      gc_in     = gc_ff;
      push      = '0;
      scan_free = 1'b0;
      last      = 1'b0;
      tok       = '0;

      unique case (phase_ff)
         PH_MINUS: begin
            if (digit) begin
               phase_in = PH_NUMBER;
               acc_in   = acc_new;
               sat_in   = sat_new;
               neg_in   = 1'b1;
            end else begin
               // lone minus becomes an other token; the byte is rescanned
               last       = group_full(gc_in, eff_max);
               push.first = form_token(KIND_OTHER, 64'd0, to16(start_ff), 16'd1, last);
               push.count = 2'd1;
               gc_in      = last ? 8'd0 : gc_in + 8'd1;
               phase_in   = PH_BETWEEN;
               scan_free  = 1'b1;
            end
         end
         PH_NUMBER: begin
            if (digit) begin
               acc_in = acc_new;
               sat_in = sat_new;
            end else begin
               last       = ends || group_full(gc_in, eff_max);
               push.first = form_token(neg_ff ? KIND_NEG : KIND_NAT, acc_ff, to16(start_ff),
                                       to16(len), last);
               push.count = 2'd1;
               gc_in      = last ? 8'd0 : gc_in + 8'd1;
               phase_in   = PH_BETWEEN;
               scan_free  = (text_byte == CH_NUL);
            end
         end
         PH_IDENT: begin
            if (!(is_alpha(text_byte) || digit)) begin
               last       = ends || group_full(gc_in, eff_max);
               push.first = form_token(KIND_IDENT, 64'd0, to16(start_ff), to16(len), last);
               push.count = 2'd1;
               gc_in      = last ? 8'd0 : gc_in + 8'd1;
               phase_in   = PH_BETWEEN;
               scan_free  = (text_byte == CH_NUL);
            end
         end
         default: begin
            // between tokens
            scan_free = 1'b1;
         end
      endcase

      if (scan_free) begin
         priority if (text_byte == CH_NUL) begin
            if ((push.count == 2'd0) || (push.first.kind == KIND_OTHER)) begin
               tok = form_token(KIND_END, 64'd0, to16(pos_ff), 16'd0, 1'b1);
               if (push.count == 2'd0) begin
                  push.first = tok;
               end else begin
                  push.second = tok;
               end
               push.count = push.count + 2'd1;
            end
         end else if (is_space(text_byte)) begin
            phase_in = phase_in;
         end else if (text_byte == CH_MINUS) begin
            phase_in = PH_MINUS;
            start_in = pos_ff;
         end else if (digit) begin
            phase_in = PH_NUMBER;
            neg_in   = 1'b0;
            acc_in   = acc_new;
            sat_in   = sat_new;
            start_in = pos_ff;
         end else if (is_alpha(text_byte)) begin
            phase_in = PH_IDENT;
            start_in = pos_ff;
         end else begin
            last = group_full(gc_in, eff_max);
            tok  = form_token(KIND_OTHER, 64'd0, to16(pos_ff), 16'd1, last);
            if (push.count == 2'd0) begin
               push.first = tok;
            end else begin
               push.second = tok;
            end
            push.count = push.count + 2'd1;
            gc_in      = last ? 8'd0 : gc_in + 8'd1;
         end
      end

      // End of text restarts the whole scan at offset zero
      if (text_byte == CH_NUL) begin
         phase_in = PH_BETWEEN;
         acc_in   = 64'd0;
         sat_in   = 1'b0;
         neg_in   = 1'b0;
         start_in = '0;
         pos_in   = '0;
         gc_in    = 8'd0;
      end else begin
         pos_in = pos_ff + OFFSET_BITS'(1);
      end

      if (!step) begin
         push.count = 2'd0;
      end
   end

   // Advance the scan state once per scanned byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BETWEEN;
         acc_ff   <= 64'd0;
         sat_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         start_ff <= '0;
         pos_ff   <= '0;
         gc_ff    <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         sat_ff   <= sat_in;
         neg_ff   <= neg_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         gc_ff    <= gc_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/lts_result_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lts_result_queue
   import lts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop,
   output logic      room,
   output logic      out_valid,
   output token_type out_token
);

   token_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic [QUEUE_PTR_W-1:0] wr_next;

   assign wr_next   = wr_ptr_ff + QUEUE_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
   assign count_in  = count_ff + (QUEUE_PTR_W + 1)'(push.count) - (QUEUE_PTR_W + 1)'(pop);

   // Room for a byte that yields two tokens
   assign room      = count_ff <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_token = entry_ff[rd_ptr_ff];

   // Store tokens in order
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   // Track pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sim/tb_line_token_scanner.sv =====
`timescale 1ns / 1ps

import lts_pkg::*;

// Scanner position between bytes
typedef enum logic [3:0] {
   SCAN_IDLE   = 4'b0001,
   SCAN_MINUS  = 4'b0010,
   SCAN_NUMBER = 4'b0100,
   SCAN_WORD   = 4'b1000
} scan_state_type;

function automatic bit char_is_digit(logic [7:0] c);
   return (c >= CH_ZERO) && (c <= CH_NINE);
endfunction

function automatic bit char_is_letter(logic [7:0] c);
   return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
endfunction

function automatic bit char_is_blank(logic [7:0] c);
   return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT)
      || (c == CH_FF) || (c == CH_CR);
endfunction

// Token predictor and the store of tokens still owed by the scanner
class token_scoreboard;
   token_type      pending[$];
   scan_state_type state;
   logic [63:0]    acc;
   bit             sat;
   bit             neg;
   logic [15:0]    start;
   logic [15:0]    pos;
   logic [7:0]     grp;
   logic [7:0]     group_cap;
   int             errors;
   int             checked;
   int             bytes_seen;
   int             groups_closed;
   int             saturated;

   function new();
      state = SCAN_IDLE;
      acc = '0;
      sat = 1'b0;
      neg = 1'b0;
      start = '0;
      pos = '0;
      grp = '0;
      group_cap = MAX_TOKENS_RESET;
   endfunction

   function void set_limit(logic [7:0] value);
      group_cap = value;
   endfunction

   // Fold one decimal digit in, clamping at the limit of the number kind
   function void add_digit(logic [3:0] d);
      logic [63:0] ceiling;
      ceiling = neg ? NEG_LIMIT : NAT_LIMIT;
      if (sat || acc > (ceiling - 64'(d)) / 64'd10) begin
         acc = ceiling;
         sat = 1'b1;
      end else begin
         acc = acc * 64'd10 + 64'(d);
      end
   endfunction

   // Queue one token and advance the group count
   function void emit(kind_type kind, logic [63:0] mag, logic [15:0] origin,
                      logic [15:0] span, bit forced);
      token_type t;
      int        cap;
      bit        closing;
      cap = (group_cap == 0) ? 1 : int'(group_cap);
      closing = forced || (int'(grp) + 1 >= cap);
      grp = closing ? 8'd0 : grp + 8'd1;
      t.kind = kind;
      t.magnitude = mag;
      t.start_offset = origin;
      t.token_length = span;
      t.last_of_group = closing;
      pending.push_back(t);
      if (closing) groups_closed++;
      if ((kind == KIND_NEG || kind == KIND_NAT) && sat) saturated++;
   endfunction

   // Note one accepted text byte and predict the tokens it releases
   function void note_byte(logic [7:0] c);
      logic [15:0] span;
      bit          closes;
      bit          swallowed;
      bit          made;
      kind_type    first_kind;
      span = pos - start;
      closes = (c == CH_LF) || (c == CH_NUL);
      swallowed = 1'b0;
      made = 1'b0;
      first_kind = KIND_END;
      bytes_seen++;
      case (state)
         SCAN_MINUS: begin
            if (char_is_digit(c)) begin
               state = SCAN_NUMBER;
               neg = 1'b1;
               sat = 1'b0;
               acc = '0;
               add_digit(4'(c - CH_ZERO));
               pos = pos + 16'd1;
               return;
            end
            // lone minus stands as a character of its own
            emit(KIND_OTHER, '0, start, 16'd1, 1'b0);
            made = 1'b1;
            first_kind = KIND_OTHER;
            state = SCAN_IDLE;
         end
         SCAN_NUMBER: begin
            if (char_is_digit(c)) begin
               add_digit(4'(c - CH_ZERO));
            end else begin
               first_kind = neg ? KIND_NEG : KIND_NAT;
               emit(first_kind, acc, start, span, closes);
               made = 1'b1;
               state = SCAN_IDLE;
               swallowed = (c != CH_NUL);
            end
         end
         SCAN_WORD: begin
            if (!(char_is_letter(c) || char_is_digit(c))) begin
               first_kind = KIND_IDENT;
               emit(KIND_IDENT, '0, start, span, closes);
               made = 1'b1;
               state = SCAN_IDLE;
               swallowed = (c != CH_NUL);
            end
         end
         default: ;
      endcase

      // Between tokens: start a new one, skip blanks or close the text
      if (state == SCAN_IDLE && !swallowed) begin
         if (c == CH_NUL) begin
            if (!made || first_kind == KIND_OTHER) emit(KIND_END, '0, pos, 16'd0, 1'b1);
         end else if (c == CH_MINUS) begin
            state = SCAN_MINUS;
            start = pos;
         end else if (char_is_digit(c)) begin
            state = SCAN_NUMBER;
            neg = 1'b0;
            sat = 1'b0;
            acc = '0;
            start = pos;
            add_digit(4'(c - CH_ZERO));
         end else if (char_is_letter(c)) begin
            state = SCAN_WORD;
            start = pos;
         end else if (!char_is_blank(c)) begin
            emit(KIND_OTHER, '0, pos, 16'd1, 1'b0);
         end
      end

      // End of text restarts offsets and the group
      if (c == CH_NUL) begin
         state = SCAN_IDLE;
         acc = '0;
         sat = 1'b0;
         neg = 1'b0;
         start = '0;
         pos = '0;
         grp = '0;
      end else begin
         pos = pos + 16'd1;
      end
   endfunction

   function string describe(token_type t);
      return $sformatf("kind %0d mag %0d start %0d len %0d last %0b", t.kind, t.magnitude,
                       t.start_offset, t.token_length, t.last_of_group);
   endfunction

   function void fail_note(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
   endfunction

   // Compare one delivered token against the oldest prediction
   function void check(token_type got);
      token_type want;
      checked++;
      if (pending.size() == 0) begin
         fail_note($sformatf("unexpected token: %s", describe(got)));
         return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind || got.magnitude !== want.magnitude
          || got.start_offset !== want.start_offset || got.token_length !== want.token_length
          || got.last_of_group !== want.last_of_group)
         fail_note($sformatf("token mismatch: expected %s, got %s", describe(want),
                             describe(got)));
   endfunction
endclass

module tb_line_token_scanner;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   localparam int CYCLE_LIMIT   = 200_000;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;

   lts_req_if req_bus ();
   lts_rsp_if rsp_bus ();

   token_scoreboard board = new();

   logic [7:0]     text_buf[$];
   int             fill_count;
   int             settings_used;
   int unsigned    cycle_count;
   int unsigned    stall_tick;
   stall_mode_type stall_mode = STALL_NONE;

   string limit_numbers[4] = '{"18446744073709551615", "18446744073709551616",
                               "9223372036854775808", "9223372036854775809"};

   line_token_scanner DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // Drive token ready on the current stall pattern
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      case (stall_mode)
         STALL_NONE:  rsp_bus.ready <= 1'b1;
         STALL_LIGHT: rsp_bus.ready <= ($urandom_range(99) >= 25);
         STALL_HEAVY: rsp_bus.ready <= ($urandom_range(99) >= 70);
         default:     rsp_bus.ready <= ((stall_tick % 7) >= 3);
      endcase
   end

   // Check every token taken from the scanner
   always @(posedge clock) begin
      token_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.kind = kind_type'(rsp_bus.token_kind);
         got.magnitude = rsp_bus.magnitude;
         got.start_offset = rsp_bus.start_offset;
         got.token_length = rsp_bus.token_length;
         got.last_of_group = rsp_bus.last_of_group;
         board.check(got);
      end
   end

   function automatic void put(logic [7:0] b);
      text_buf.push_back(b);
      if (!char_is_blank(b)) fill_count++;
   endfunction

   function automatic void push_str(string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endfunction

   function automatic logic [7:0] rand_letter();
      return $urandom_range(1) ? CH_UP_A + 8'($urandom_range(25))
                               : CH_LO_A + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(9));
   endfunction

   // Any byte that stands alone as a one-character token
   function automatic logic [7:0] rand_other();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (char_is_digit(c) || char_is_letter(c) || char_is_blank(c) || c == CH_MINUS);
      return c;
   endfunction

   // Append one random token and its terminator, or a noise byte
   task automatic add_token(input int other_pct, input int lf_pct, input int end_pct,
                            input int noise_pct);
      int pick;
      int rest;
      int n;
      pick = $urandom_range(99);
      if (pick < noise_pct) begin
         put(8'($urandom_range(255)));
         return;
      end
      rest = 100 - other_pct;
      pick = $urandom_range(99);
      if (pick < other_pct) begin
         put(rand_other());
      end else if (pick < other_pct + rest / 8) begin
         put(CH_MINUS);
      end else if (pick < other_pct + rest / 4) begin
         if ($urandom_range(1)) put(CH_MINUS);
         push_str(limit_numbers[$urandom_range(3)]);
      end else if (pick < other_pct + 5 * rest / 8) begin
         if ($urandom_range(2) == 0) put(CH_MINUS);
         n = ($urandom_range(9) == 0) ? $urandom_range(15, 26) : $urandom_range(1, 6);
         repeat (n) put(rand_digit());
      end else begin
         put(rand_letter());
         repeat ($urandom_range(0, 10)) put($urandom_range(2) ? rand_letter() : rand_digit());
      end

      // terminator; sometimes none, so the next token runs on
      pick = $urandom_range(99);
      if (pick < end_pct) begin
         put(CH_NUL);
      end else if (pick < end_pct + lf_pct) begin
         put(CH_LF);
      end else if (pick < 60) begin
         put(CH_SPACE);
      end else if (pick < 75) begin
         case ($urandom_range(3))
            0:       put(CH_TAB);
            1:       put(CH_VT);
            2:       put(CH_FF);
            default: put(CH_CR);
         endcase
      end else if (pick < 90) begin
         put(rand_other());
      end
   endtask

   // Stream the text buffer in bursts with random gaps
   task automatic send_text(input int gap_max);
      int burst;
      int gap;
      burst = 0;
      foreach (text_buf[i]) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_bus.valid <= 1'b1;
         req_bus.text_byte <= text_buf[i];
         do @(posedge clock); while (req_bus.ready !== 1'b1);
         board.note_byte(text_buf[i]);
         burst--;
      end
      req_bus.valid <= 1'b0;
      text_buf.delete();
   endtask

   // Wait for owed tokens, then let the pipeline empty
   task automatic settle();
      int waited;
      waited = 0;
      while (board.pending.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_limit(value);
      settings_used++;
   endtask

   task automatic run_phase(input logic [7:0] cap, input int other_pct, input int lf_pct,
                            input int end_pct, input int noise_pct, input int gap_max,
                            input stall_mode_type stall, input int quota);
      settle();
      write_limit(cap);
      stall_mode = stall;
      fill_count = 0;
      while (fill_count < quota) add_token(other_pct, lf_pct, end_pct, noise_pct);
      send_text(gap_max);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.text_byte = 8'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every kind, lone minus, every blank byte, end of text in and between tokens
      stall_mode = STALL_LIGHT;
      push_str("12");
      put(CH_LF);
      push_str("-9 ab1;-#");
      put(8'hFF);
      put(8'h80);
      put(CH_LF);
      put(CH_MINUS);
      put(CH_NUL);
      put(CH_NUL);
      push_str("7");
      put(CH_NUL);
      put(CH_SPACE);
      put(CH_TAB);
      put(CH_VT);
      put(CH_FF);
      put(CH_CR);
      push_str("q");
      put(CH_NUL);
      send_text(2);

      // Random text under several group sizes and handshake patterns
      run_phase(8'd255, 70, 0, 0, 2, 0, STALL_NONE, 240);
      run_phase(8'd1, 25, 10, 5, 8, 4, STALL_LIGHT, 150);
      run_phase(8'd3, 25, 8, 4, 8, 3, STALL_PERIODIC, 150);
      run_phase(8'd0, 30, 8, 4, 6, 2, STALL_HEAVY, 110);
      run_phase(8'($urandom_range(2, 40)), 25, 12, 6, 10, 6, STALL_LIGHT, 165);
      run_phase(MAX_TOKENS_RESET, 25, 10, 5, 10, 0, STALL_PERIODIC, 160);

      settle();
      if (board.pending.size() != 0)
         board.fail_note($sformatf("%0d predicted tokens never arrived", board.pending.size()));

      $display("Scanned %0d text bytes under %0d max_tokens settings and four ready patterns.",
               board.bytes_seen, settings_used);
      $display("Checked %0d tokens: %0d group closures, %0d saturated numbers, %0d errors.",
               board.checked, board.groups_closed, board.saturated, board.errors);
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
